FILE: design/cfa_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous frame allocator package
// Shared widths, request and result codes, and the bitmap access struct.
// ----------------------------------------------------------------------------
package cfa_pkg;

    // Frame total and the widths that follow from it.
    localparam int NUM_FRAMES  = 256;
    localparam int FRAME_IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FRAME_CNT_W = $clog2(NUM_FRAMES + 1);

    // Fixed field widths of the request and result items.
    localparam int FIELD_W  = 9;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = (FIELD_W > FRAME_CNT_W) ? FIELD_W : FRAME_CNT_W;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FIELD_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE         = 2'd0,
        STATUS_ALLOC_FAIL   = 2'd1,
        STATUS_FREE_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } state_t;

    // One write port and one read port into the allocation bitmap.
    typedef struct packed {
        logic                   wr_en;
        logic [FRAME_IDX_W-1:0] wr_addr;
        logic                   wr_data;
        logic [FRAME_IDX_W-1:0] rd_addr;
    } bitmap_req_t;

endpackage

FILE: design/cfa_bitmap.sv
// ----------------------------------------------------------------------------
// Frame allocation bitmap
// One bit per frame, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cfa_bitmap (
    input  logic                clk,
    input  cfa_pkg::bitmap_req_t req,
    output logic                rd_data
);
    import cfa_pkg::*;

    logic mem [NUM_FRAMES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

FILE: design/contiguous_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// Contiguous frame allocator core
// First-fit allocator of contiguous frame runs over a one-bit-per-frame map.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: s_tuser carries the command (allocate a
// run or free one frame), s_tdata the frame count and the handle. Every
// request produces exactly one result on the m_ channel: m_tuser carries the
// status and m_tdata the start handle (first frame index plus one, or zero).
// An allocate walks the bitmap from frame 0 upward, one frame per cycle,
// through a single registered read port, and then marks the run it found one
// frame per cycle through the single write port. One request is in work at
// a time, and s_tready is high only while the sequencer is idle.
// After reset a clearing pass writes every bitmap entry free, one per cycle,
// with s_tready low. Results sit in an output register; while the receiver
// stalls the next request can still be taken, and its result waits in the
// sequencer until the output register empties.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: frame_count [8:0], frame_handle [17:9], zero pad above.
    input  logic [cfa_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd [0].
    input  logic                          s_tuser,
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: start_handle [8:0], zero pad above.
    output logic [cfa_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: status [1:0].
    output logic [cfa_pkg::STATUS_W-1:0]  m_tuser
);
    import cfa_pkg::*;

    localparam logic [FRAME_IDX_W-1:0] LAST_IDX   = FRAME_IDX_W'(NUM_FRAMES - 1);
    localparam logic [FRAME_CNT_W-1:0] FRAME_TOT  = FRAME_CNT_W'(NUM_FRAMES);
    localparam logic [CMP_W-1:0]       FRAME_TOTC = CMP_W'(NUM_FRAMES);

    state_t                 state_reg, state_next;

    // Latched request.
    cmd_t                   req_cmd_reg, req_cmd_next;
    logic [FIELD_W-1:0]     req_count_reg, req_count_next;
    logic [FIELD_W-1:0]     req_handle_reg, req_handle_next;

    // Scan and mark datapath.
    logic [FRAME_CNT_W-1:0] issue_reg, issue_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [FRAME_IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [FRAME_CNT_W-1:0] run_reg, run_next;
    logic [FRAME_IDX_W-1:0] first_reg, first_next;
    logic [FRAME_CNT_W-1:0] count_reg, count_next;

    // Pending result and output register.
    status_t                pend_status_reg, pend_status_next;
    logic [FIELD_W-1:0]     pend_start_reg, pend_start_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [FIELD_W-1:0]     out_start_reg, out_start_next;

    bitmap_req_t            bm_req;
    logic                   bm_rd_data;

    // Decode of the latched request.
    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       handle_ext;
    logic [CMP_W-1:0]       handle_m1;
    logic                   count_ok;
    logic                   handle_ok;

    // Scan step.
    logic                   issuing;
    logic [FRAME_CNT_W-1:0] run_inc;
    logic [FRAME_IDX_W-1:0] first_cand;
    logic                   found;
    logic                   scan_end;
    logic [CMP_W-1:0]       start_calc;
    logic                   out_free;

    assign count_ext  = CMP_W'(req_count_reg);
    assign handle_ext = CMP_W'(req_handle_reg);
    assign handle_m1  = handle_ext - CMP_W'(1);
    assign count_ok   = (count_ext != '0) && (count_ext <= FRAME_TOTC);
    assign handle_ok  = (handle_ext != '0) && (handle_ext <= FRAME_TOTC);

    assign issuing    = (issue_reg < FRAME_TOT);
    assign run_inc    = run_reg + FRAME_CNT_W'(1);
    assign first_cand = (run_reg == '0) ? chk_idx_reg : first_reg;
    assign found      = chk_valid_reg && !bm_rd_data && (run_inc == count_reg);
    assign scan_end   = chk_valid_reg && (chk_idx_reg == LAST_IDX);
    assign start_calc = CMP_W'(first_cand) + CMP_W'(1);
    assign out_free   = !out_valid_reg || m_tready;

    cfa_bitmap u_bitmap (
        .clk     (clk),
        .req     (bm_req),
        .rd_data (bm_rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (issue_reg[FRAME_IDX_W-1:0] == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (req_cmd_reg == CMD_ALLOC && count_ok)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (found)
                begin
                    state_next = ST_MARK;
                end
                else if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK:
            begin
                if (run_reg == FRAME_CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and bitmap port.
    always_comb
    begin
        req_cmd_next     = req_cmd_reg;
        req_count_next   = req_count_reg;
        req_handle_next  = req_handle_reg;
        issue_next       = issue_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        run_next         = run_reg;
        first_next       = first_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_start_next  = pend_start_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_start_next   = out_start_reg;
        bm_req.wr_en     = 1'b0;
        bm_req.wr_addr   = issue_reg[FRAME_IDX_W-1:0];
        bm_req.wr_data   = 1'b0;
        bm_req.rd_addr   = issue_reg[FRAME_IDX_W-1:0];
        s_tready         = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                bm_req.wr_en = 1'b1;
                if (issue_reg[FRAME_IDX_W-1:0] == LAST_IDX)
                begin
                    issue_next = '0;
                end
                else
                begin
                    issue_next = issue_reg + FRAME_CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    req_cmd_next    = cmd_t'(s_tuser);
                    req_count_next  = s_tdata[FIELD_W-1:0];
                    req_handle_next = s_tdata[2*FIELD_W-1:FIELD_W];
                end
            end
            ST_START:
            begin
                pend_start_next = '0;
                issue_next      = '0;
                run_next        = '0;
                count_next      = count_ext[FRAME_CNT_W-1:0];
                if (req_cmd_reg == CMD_FREE)
                begin
                    // Free of a single frame; null or out-of-range handles are ignored.
                    bm_req.wr_addr = handle_m1[FRAME_IDX_W-1:0];
                    bm_req.wr_en   = handle_ok;
                    pend_status_next = handle_ok ? STATUS_DONE : STATUS_FREE_INVALID;
                end
                else
                begin
                    pend_status_next = STATUS_ALLOC_FAIL;
                end
            end
            ST_SCAN:
            begin
                // Each read is issued in the cycle before its returned bit is checked.
                if (issuing)
                begin
                    issue_next     = issue_reg + FRAME_CNT_W'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[FRAME_IDX_W-1:0];
                end
                if (chk_valid_reg)
                begin
                    if (bm_rd_data)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next   = run_inc;
                        first_next = first_cand;
                    end
                end
                if (found)
                begin
                    // Run found: the run length register now counts frames left to mark.
                    run_next         = count_reg;
                    first_next       = first_cand;
                    pend_status_next = STATUS_DONE;
                    pend_start_next  = start_calc[FIELD_W-1:0];
                end
            end
            ST_MARK:
            begin
                bm_req.wr_en   = 1'b1;
                bm_req.wr_addr = first_reg;
                bm_req.wr_data = 1'b1;
                first_next     = first_reg + FRAME_IDX_W'(1);
                run_next       = run_reg - FRAME_CNT_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_start_next  = pend_start_reg;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_cmd_reg     <= req_cmd_next;
        req_count_reg   <= req_count_next;
        req_handle_reg  <= req_handle_next;
        chk_idx_reg     <= chk_idx_next;
        run_reg         <= run_next;
        first_reg       <= first_next;
        count_reg       <= count_next;
        pend_status_reg <= pend_status_next;
        pend_start_reg  <= pend_start_next;
        out_status_reg  <= out_status_next;
        out_start_reg   <= out_start_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'(out_start_reg);

`ifndef SYNTHESIS
    // A request is never taken twice in a row: the sequencer leaves idle on accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request channel stayed ready after an accept");

    // A failed allocate or an ignored free never reports a handle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_ALLOC_FAIL || m_tuser == STATUS_FREE_INVALID)
        |-> m_tdata == '0)
        else $error("failing result carries a nonzero start handle");

    // A reported start handle lies inside the frame map.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> CMP_W'(m_tdata[FIELD_W-1:0]) <= FRAME_TOTC)
        else $error("start handle beyond the frame total");

    // During the scan the current free run stays shorter than the request.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> run_reg < count_reg)
        else $error("free run length reached the count without a match");

    // Marking always has at least one frame left to write.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MARK |-> run_reg != '0)
        else $error("mark pass entered with nothing left to mark");
`endif

endmodule
